// File: rtl/bse_pkg.sv
// Shared types, constants and helper functions of the bitmap set engine.
`timescale 1ns / 1ps

package bse_pkg;

   localparam int INDEX_BITS  = 16;
   localparam int WORD_BITS   = 64;
   localparam int KEY_BITS    = 16;
   localparam int COUNT_BITS  = 17;
   localparam int OFFSET_BITS = $clog2(WORD_BITS);
   localparam int ADDR_BITS   = INDEX_BITS - OFFSET_BITS;
   localparam int DEPTH       = 2 ** ADDR_BITS;

   localparam logic [63:0] UNIVERSE = 64'd1 << INDEX_BITS;
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);
   localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

   typedef enum logic [2:0] {
      ACT_SET      = 3'd0,
      ACT_CLEAR    = 3'd1,
      ACT_TEST     = 3'd2,
      ACT_CLR_ALL  = 3'd3,
      ACT_FIRST    = 3'd4,
      ACT_NEXT     = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RMW,
      ST_WIPE,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic                  load;
      logic                  hit;
      logic [KEY_BITS-1:0]   found;
      logic [COUNT_BITS-1:0] count;
   } result_type;

   // Word address of a key after it wraps to the universe.
   function automatic logic [ADDR_BITS-1:0] key_addr(input logic [KEY_BITS-1:0] raw);
      logic [63:0] wide;
      wide = 64'(raw) & (UNIVERSE - 64'd1);
      return ADDR_BITS'(wide >> OFFSET_BITS);
   endfunction

   // Position of the lowest set bit of a word, zero for an empty word.
   function automatic logic [OFFSET_BITS-1:0] lowest_bit(input logic [WORD_BITS-1:0] word);
      logic [OFFSET_BITS-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            idx = OFFSET_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// File: rtl/bse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bse_ram #(
   parameter int DATA_BITS = 64,
   parameter int DEPTH     = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bse_ctrl.sv
// Sequencer of the bitmap set engine: clearing sweeps, read-modify-write and word scans.
`timescale 1ns / 1ps

module bse_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_action,
   input  logic [bse_pkg::KEY_BITS-1:0]     req_key_value,
   input  logic                             rsp_free,
   output bse_pkg::result_type              result,
   output bse_pkg::ram_req_type             ram_req,
   input  logic [bse_pkg::WORD_BITS-1:0]    rd_data
);

   bse_pkg::state_type state_ff, state_in;
   bse_pkg::action_type op_ff;

   logic [bse_pkg::ADDR_BITS-1:0]   sweep_ff;
   logic [bse_pkg::ADDR_BITS-1:0]   key_addr_ff;
   logic [bse_pkg::OFFSET_BITS-1:0] key_bit_ff;
   logic [bse_pkg::ADDR_BITS-1:0]   issue_addr_ff;
   logic                            issue_done_ff;
   logic                            issue_first_ff;
   logic                            chk_valid_ff;
   logic [bse_pkg::ADDR_BITS-1:0]   chk_addr_ff;
   logic                            chk_first_ff;
   logic [bse_pkg::OFFSET_BITS-1:0] first_bit_ff;
   logic [bse_pkg::COUNT_BITS-1:0]  pop_ff;
   logic                            res_hit_ff;
   logic [bse_pkg::KEY_BITS-1:0]    res_found_ff;

   bse_pkg::action_type             req_act;
   logic                            accept;
   logic [bse_pkg::ADDR_BITS-1:0]   req_addr;
   logic [63:0]                     next_key;
   logic                            next_miss;
   logic [bse_pkg::ADDR_BITS-1:0]   start_addr;
   logic [bse_pkg::OFFSET_BITS-1:0] start_bit;
   logic [bse_pkg::WORD_BITS-1:0]   onehot;
   logic                            present;
   logic                            rmw_write;
   logic [bse_pkg::WORD_BITS-1:0]   masked;
   logic                            scan_nz;
   logic                            scan_last;
   logic                            scan_issue;
   logic                            sweeping;

   assign req_act  = bse_pkg::action_type'(req_action);
   assign accept   = req_valid && req_ready;
   assign req_addr = bse_pkg::key_addr(req_key_value);
   assign next_key = 64'(req_key_value) + 64'd1;
   assign next_miss = next_key >= bse_pkg::UNIVERSE;

   always_comb begin
      if (req_act == bse_pkg::ACT_NEXT) begin
         start_addr = bse_pkg::ADDR_BITS'(next_key >> bse_pkg::OFFSET_BITS);
         start_bit  = next_key[bse_pkg::OFFSET_BITS-1:0];
      end else begin
         start_addr = '0;
         start_bit  = '0;
      end
   end

   assign onehot  = bse_pkg::WORD_BITS'(1) << key_bit_ff;
   assign present = |(rd_data & onehot);
   assign masked  = rd_data & (chk_first_ff ? (bse_pkg::ALL_ONES << first_bit_ff)
                                            : bse_pkg::ALL_ONES);
   assign scan_nz   = |masked;
   assign scan_last = chk_addr_ff == bse_pkg::LAST_ADDR;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bse_pkg::ST_INIT: begin
            if (sweep_ff == bse_pkg::LAST_ADDR) begin
               state_in = bse_pkg::ST_IDLE;
            end
         end
         bse_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_act)
                  bse_pkg::ACT_SET, bse_pkg::ACT_CLEAR, bse_pkg::ACT_TEST: begin
                     state_in = bse_pkg::ST_RMW;
                  end
                  bse_pkg::ACT_CLR_ALL: state_in = bse_pkg::ST_WIPE;
                  bse_pkg::ACT_FIRST:   state_in = bse_pkg::ST_SCAN;
                  bse_pkg::ACT_NEXT: begin
                     state_in = next_miss ? bse_pkg::ST_RESP : bse_pkg::ST_SCAN;
                  end
                  default: state_in = bse_pkg::ST_RESP;
               endcase
            end
         end
         bse_pkg::ST_RMW: state_in = bse_pkg::ST_RESP;
         bse_pkg::ST_WIPE: begin
            if (sweep_ff == bse_pkg::LAST_ADDR) begin
               state_in = bse_pkg::ST_RESP;
            end
         end
         bse_pkg::ST_SCAN: begin
            if (chk_valid_ff && (scan_nz || scan_last)) begin
               state_in = bse_pkg::ST_RESP;
            end
         end
         bse_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = bse_pkg::ST_IDLE;
            end
         end
         default: state_in = bse_pkg::ST_INIT;
      endcase
   end

   // Output logic.
   always_comb begin
      req_ready  = state_ff == bse_pkg::ST_IDLE;
      sweeping   = (state_ff == bse_pkg::ST_INIT) || (state_ff == bse_pkg::ST_WIPE);
      scan_issue = (state_ff == bse_pkg::ST_SCAN) && !issue_done_ff;
      rmw_write  = (state_ff == bse_pkg::ST_RMW) &&
                   (((op_ff == bse_pkg::ACT_SET) && !present) ||
                    ((op_ff == bse_pkg::ACT_CLEAR) && present));

      ram_req.rd_en   = accept || scan_issue;
      ram_req.rd_addr = (state_ff == bse_pkg::ST_SCAN) ? issue_addr_ff : req_addr;
      ram_req.wr_en   = sweeping || rmw_write;
      ram_req.wr_addr = sweeping ? sweep_ff : key_addr_ff;
      if (sweeping) begin
         ram_req.wr_data = '0;
      end else if (op_ff == bse_pkg::ACT_SET) begin
         ram_req.wr_data = rd_data | onehot;
      end else begin
         ram_req.wr_data = rd_data & ~onehot;
      end

      result.load  = (state_ff == bse_pkg::ST_RESP) && rsp_free;
      result.hit   = res_hit_ff;
      result.found = res_found_ff;
      result.count = pop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bse_pkg::ST_INIT;
         sweep_ff      <= '0;
         pop_ff        <= '0;
         issue_done_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (sweeping) begin
            sweep_ff <= sweep_ff + bse_pkg::ADDR_BITS'(1);
         end

         if (accept) begin
            op_ff          <= req_act;
            key_addr_ff    <= req_addr;
            key_bit_ff     <= req_key_value[bse_pkg::OFFSET_BITS-1:0];
            res_hit_ff     <= 1'b0;
            res_found_ff   <= '0;
            issue_addr_ff  <= start_addr;
            issue_done_ff  <= 1'b0;
            issue_first_ff <= 1'b1;
            first_bit_ff   <= start_bit;
            chk_valid_ff   <= 1'b0;
            if (req_act == bse_pkg::ACT_CLR_ALL) begin
               pop_ff   <= '0;
               sweep_ff <= '0;
            end
         end

         if (state_ff == bse_pkg::ST_RMW) begin
            case (op_ff)
               bse_pkg::ACT_SET: begin
                  if (present) begin
                     res_hit_ff <= 1'b1;
                  end else begin
                     pop_ff <= pop_ff + bse_pkg::COUNT_BITS'(1);
                  end
               end
               bse_pkg::ACT_CLEAR: begin
                  if (present) begin
                     pop_ff <= pop_ff - bse_pkg::COUNT_BITS'(1);
                  end
               end
               bse_pkg::ACT_TEST: res_hit_ff <= present;
               default: res_hit_ff <= 1'b0;
            endcase
         end

         if (state_ff == bse_pkg::ST_SCAN) begin
            if (scan_issue) begin
               chk_valid_ff   <= 1'b1;
               chk_addr_ff    <= issue_addr_ff;
               chk_first_ff   <= issue_first_ff;
               issue_first_ff <= 1'b0;
               if (issue_addr_ff == bse_pkg::LAST_ADDR) begin
                  issue_done_ff <= 1'b1;
               end else begin
                  issue_addr_ff <= issue_addr_ff + bse_pkg::ADDR_BITS'(1);
               end
            end else begin
               chk_valid_ff <= 1'b0;
            end
            if (chk_valid_ff && scan_nz) begin
               res_hit_ff   <= 1'b1;
               res_found_ff <= bse_pkg::KEY_BITS'({chk_addr_ff, bse_pkg::lowest_bit(masked)});
            end
         end
      end
   end

endmodule

// File: rtl/bitmap_set_engine_core.sv
// Top level of the bitmap set engine: word memory, sequencer and result register.
`timescale 1ns / 1ps

// The engine keeps a set of integers as a bitmap, one bit per member, in a
// single word memory with one write and one registered read port. Set, clear
// and test read one word, set and clear write it back when their bit changes,
// and no new item is taken until the result is loaded. Find first and find
// next stream reads over the words from the start position, one word per
// cycle, up to the last word of the full memory depth of 1024 words. Clear
// all writes zero to every word, one word per cycle. After reset the same
// sweep runs before the first item is taken. Every result carries the member
// count after its action, and the result register lets the engine take the
// next item while a result still waits for its transfer.
module bitmap_set_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_action,
   input  logic [bse_pkg::KEY_BITS-1:0]      req_key_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [bse_pkg::KEY_BITS-1:0]      rsp_found_value,
   output logic [bse_pkg::COUNT_BITS-1:0]    rsp_member_count
);

   bse_pkg::result_type             result;
   bse_pkg::ram_req_type            ram_req;
   logic [bse_pkg::WORD_BITS-1:0]   rd_data;
   logic                            rsp_free;

   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic [bse_pkg::KEY_BITS-1:0]    rsp_found_ff;
   logic [bse_pkg::COUNT_BITS-1:0]  rsp_count_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   bse_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_key_value (req_key_value),
      .rsp_free      (rsp_free),
      .result        (result),
      .ram_req       (ram_req),
      .rd_data       (rd_data)
   );

   bse_ram #(
      .DATA_BITS (bse_pkg::WORD_BITS),
      .DEPTH     (bse_pkg::DEPTH)
   ) u_bit_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_hit_ff   <= result.hit;
         rsp_found_ff <= result.found;
         rsp_count_ff <= result.count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_found_value  = rsp_found_ff;
   assign rsp_member_count = rsp_count_ff;

endmodule
